/* rtl/core/msic_pkg.sv */
`timescale 1ns / 1ps

package msic_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned DiffW   = SampleW + 1;
  localparam int unsigned FactorW = 16;
  localparam int unsigned ScaledW = 32;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned ProdW   = CoefW + ScaledW;
  localparam int unsigned AccW    = ProdW + 2;
  localparam int unsigned FracDrop = 16;
  localparam int unsigned ShiftW  = AccW - FracDrop;
  localparam int unsigned FieldW  = 32;
  localparam int unsigned RowW    = 3 * CoefW;
  localparam int unsigned GainCodeW = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = RowW;
  localparam int unsigned Axes    = 3;

  localparam logic [FactorW-1:0] UnityQ12 = 16'd4096;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OFFSET_X    = 3'd0,
    CFG_OFFSET_Y    = 3'd1,
    CFG_OFFSET_Z    = 3'd2,
    CFG_MATRIX_ROW0 = 3'd3,
    CFG_MATRIX_ROW1 = 3'd4,
    CFG_MATRIX_ROW2 = 3'd5,
    CFG_GAIN_CODE   = 3'd6
  } cfg_idx_e;

  localparam logic [RowW-1:0] Row0Reset = 48'h0000_0000_1000;
  localparam logic [RowW-1:0] Row1Reset = 48'h0000_1000_0000;
  localparam logic [RowW-1:0] Row2Reset = 48'h1000_0000_0000;
  localparam logic [GainCodeW-1:0] GainCodeReset = 3'd1;

  typedef struct packed {
    logic en_mul;
    logic en_out;
  } lane_ctrl_t;

  // counts-to-milligauss gain per range code, unsigned Q4.12
  function automatic logic [FactorW-1:0] gain_q12(input logic [GainCodeW-1:0] code);
    logic [FactorW-1:0] g;
    case (code)
      3'd0:    g = 16'd299;
      3'd1:    g = 16'd3768;
      3'd2:    g = 16'd4997;
      3'd3:    g = 16'd6226;
      3'd4:    g = 16'd9298;
      3'd5:    g = 16'd10486;
      3'd6:    g = 16'd12411;
      3'd7:    g = 16'd17818;
      default: g = 16'd0;
    endcase
    return g;
  endfunction

endpackage

/* rtl/core/msic_if.sv */
`timescale 1ns / 1ps

interface msic_in_if import msic_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic signed [SampleW-1:0] sample_x;
  logic signed [SampleW-1:0] sample_y;
  logic signed [SampleW-1:0] sample_z;

  modport source (output valid, func, sample_x, sample_y, sample_z, input ready);
  modport sink   (input valid, func, sample_x, sample_y, sample_z, output ready);
endinterface

interface msic_out_if import msic_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [FieldW-1:0] field_x;
  logic signed [FieldW-1:0] field_y;
  logic signed [FieldW-1:0] field_z;
  logic                     clipped;

  modport source (output valid, field_x, field_y, field_z, clipped, input ready);
  modport sink   (input valid, field_x, field_y, field_z, clipped, output ready);
endinterface

interface msic_cfg_if import msic_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/magnetometer_hard_soft_iron_correct.sv */
`timescale 1ns / 1ps

// Hard/soft-iron correction for a three-axis magnetometer. Each request carries one raw
// sample and a mode bit; the block subtracts the per-axis offsets, optionally scales by the
// range gain, applies the 3x3 soft-iron matrix and returns three saturated Q24.8 values plus
// a clip flag. It takes one request per clock while a stalled output has not backed it up.
// A request passes one stage for offset and gain, one for the nine coefficient products
// (three row lanes of three multipliers), and the output register that holds the summed,
// floored and saturated rows. A stalled output backs up stage by stage, so empty stages
// keep accepting requests. Configuration writes are taken every cycle and must be issued
// only while the pipeline is empty.
module magnetometer_hard_soft_iron_correct import msic_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  msic_in_if.sink     in_i,
  msic_out_if.source  out_o,
  msic_cfg_if.sink    cfg_i
);

  logic signed [SampleW-1:0] offset_q [Axes];
  logic [RowW-1:0]           row_q [Axes];
  logic [GainCodeW-1:0]      gain_code_q;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  lane_ctrl_t lane_ctrl;

  logic signed [ScaledW-1:0] scaled [Axes];
  logic signed [SampleW-1:0] sample [Axes];
  logic signed [FieldW-1:0]  field [Axes];
  logic [Axes-1:0]           clip;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q[0] <= '0;
      offset_q[1] <= '0;
      offset_q[2] <= '0;
      row_q[0]    <= Row0Reset;
      row_q[1]    <= Row1Reset;
      row_q[2]    <= Row2Reset;
      gain_code_q <= GainCodeReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_OFFSET_X:    offset_q[0] <= cfg_i.data[SampleW-1:0];
        CFG_OFFSET_Y:    offset_q[1] <= cfg_i.data[SampleW-1:0];
        CFG_OFFSET_Z:    offset_q[2] <= cfg_i.data[SampleW-1:0];
        CFG_MATRIX_ROW0: row_q[0]    <= cfg_i.data[RowW-1:0];
        CFG_MATRIX_ROW1: row_q[1]    <= cfg_i.data[RowW-1:0];
        CFG_MATRIX_ROW2: row_q[2]    <= cfg_i.data[RowW-1:0];
        CFG_GAIN_CODE:   gain_code_q <= cfg_i.data[GainCodeW-1:0];
        default: ;
      endcase
    end
  end

  // a stage advances when it is empty or the next one advances
  assign rdy3 = !v3_q || out_o.ready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_i.ready = rdy1;

  assign lane_ctrl.en_mul = rdy2;
  assign lane_ctrl.en_out = rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_i.valid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign sample[0] = in_i.sample_x;
  assign sample[1] = in_i.sample_y;
  assign sample[2] = in_i.sample_z;

  for (genvar j = 0; j < Axes; j++) begin : g_axis
    msic_scale u_scale (
      .clk_i       (clk_i),
      .en_i        (rdy1),
      .func_i      (in_i.func),
      .gain_code_i (gain_code_q),
      .sample_i    (sample[j]),
      .offset_i    (offset_q[j]),
      .scaled_o    (scaled[j])
    );
  end

  for (genvar i = 0; i < Axes; i++) begin : g_row
    msic_lane u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (lane_ctrl),
      .row_i    (row_q[i]),
      .scaled_i (scaled),
      .field_o  (field[i]),
      .clip_o   (clip[i])
    );
  end

  // merge: any saturated row flags the request
  assign out_o.valid   = v3_q;
  assign out_o.field_x = field[0];
  assign out_o.field_y = field[1];
  assign out_o.field_z = field[2];
  assign out_o.clipped = |clip;

endmodule

/* rtl/core/msic_scale.sv */
`timescale 1ns / 1ps

module msic_scale import msic_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic                      func_i,
  input  logic [GainCodeW-1:0]      gain_code_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic signed [SampleW-1:0] offset_i,
  output logic signed [ScaledW-1:0] scaled_o
);

  logic signed [DiffW-1:0]     diff;
  logic [FactorW-1:0]          factor;
  logic signed [DiffW+FactorW:0] prod;
  logic signed [ScaledW-1:0]   scaled_q;

  assign diff   = DiffW'(sample_i) - DiffW'(offset_i);
  assign factor = func_i ? gain_q12(gain_code_i) : UnityQ12;
  assign prod   = (DiffW+FactorW+1)'(diff) * $signed({1'b0, factor});

  // magnitude stays below 2^31 for every code, so the top bits are sign copies
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      scaled_q <= prod[ScaledW-1:0];
    end
  end

  assign scaled_o = scaled_q;

endmodule

/* rtl/core/msic_lane.sv */
`timescale 1ns / 1ps

module msic_lane import msic_pkg::*; (
  input  logic                      clk_i,
  input  lane_ctrl_t                ctrl_i,
  input  logic [RowW-1:0]           row_i,
  input  logic signed [ScaledW-1:0] scaled_i [Axes],
  output logic signed [FieldW-1:0]  field_o,
  output logic                      clip_o
);

  logic signed [ProdW-1:0]  prod_q [Axes];
  logic signed [AccW-1:0]   acc;
  logic signed [ShiftW-1:0] shifted;
  logic signed [FieldW-1:0] field_d, field_q;
  logic                     clip_d, clip_q;

  for (genvar j = 0; j < Axes; j++) begin : g_mul
    always_ff @(posedge clk_i) begin
      if (ctrl_i.en_mul) begin
        prod_q[j] <= $signed(row_i[j*CoefW +: CoefW]) * scaled_i[j];
      end
    end
  end

  assign acc     = AccW'(prod_q[0]) + AccW'(prod_q[1]) + AccW'(prod_q[2]);
  // arithmetic shift floors toward minus infinity
  assign shifted = ShiftW'(acc >>> FracDrop);

  always_comb begin
    if (shifted > ShiftW'(signed'({1'b0, {(FieldW-1){1'b1}}}))) begin
      field_d = {1'b0, {(FieldW-1){1'b1}}};
      clip_d  = 1'b1;
    end else if (shifted < -(ShiftW'(signed'({1'b0, 1'b1, {(FieldW-1){1'b0}}})))) begin
      field_d = {1'b1, {(FieldW-1){1'b0}}};
      clip_d  = 1'b1;
    end else begin
      field_d = shifted[FieldW-1:0];
      clip_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_out) begin
      field_q <= field_d;
      clip_q  <= clip_d;
    end
  end

  assign field_o = field_q;
  assign clip_o  = clip_q;

endmodule
